/* src/ohlcv_pkg.sv */
// shared types and constants for the ohlcv bar aggregator
package ohlcv_pkg;

    localparam int STAMP_W = 40;
    localparam int PRICE_W = 32;
    localparam int VOL_W   = 32;
    localparam int SUM_W   = 48;
    localparam int LEN_W   = 11;
    localparam int IDX_W   = 2;
    localparam int DATA_W  = 40;

    localparam logic [IDX_W-1:0] REG_BLOCK_LENGTH = 2'd0;
    localparam logic [IDX_W-1:0] REG_START_TIME   = 2'd1;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [PRICE_W-1:0] open_p;
        logic [PRICE_W-1:0] high_p;
        logic [PRICE_W-1:0] low_p;
        logic [PRICE_W-1:0] close_p;
        logic [SUM_W-1:0]   volume;
        logic [PRICE_W-1:0] bid_p;
        logic [PRICE_W-1:0] ask_p;
    } bar_t;

endpackage

/* src/ohlcv_bar_aggregator_unit.sv */
// ohlcv bar aggregator: merges base candles into higher-timeframe bars
//
// input channel (in_valid/in_ready) takes one candle beat per cycle while
// in_ready is high; the output channel (out_valid/out_ready) gives one bar
// beat per completed group of block_length candles. candles are dropped until
// one whose stamp equals start_time, and from then on every candle counts.
// a candle is folded into the running group in the cycle it is accepted;
// the bar that closes a group is registered into a two-entry output queue and
// shows on the output once any bar ahead of it has been taken.
// throughput is one candle per cycle; in_ready drops only when both queue
// entries hold bars the receiver has not taken, so one finished bar may
// wait while further candles keep coming in.
// the config port writes block_length (index 0) or start_time (index 1); a
// write of either drops any partial group; start_time also rearms the start
// match. writes must go in only while the block is idle (not enforced).
// reset (rst_n low) empties the queue, clears the running group and sets
// block_length to 1 and start_time to 0.
module ohlcv_bar_aggregator_unit #(
    parameter int MAX_GROUP  = 1440,
    parameter int PRICE_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [ohlcv_pkg::IDX_W-1:0]    cfg_index,
    input  logic [ohlcv_pkg::DATA_W-1:0]   cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ohlcv_pkg::STAMP_W-1:0]  stamp,
    input  logic [ohlcv_pkg::PRICE_W-1:0]  open_price,
    input  logic [ohlcv_pkg::PRICE_W-1:0]  high_price,
    input  logic [ohlcv_pkg::PRICE_W-1:0]  low_price,
    input  logic [ohlcv_pkg::PRICE_W-1:0]  close_price,
    input  logic [ohlcv_pkg::VOL_W-1:0]    volume,
    input  logic [ohlcv_pkg::PRICE_W-1:0]  bid_price,
    input  logic [ohlcv_pkg::PRICE_W-1:0]  ask_price,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ohlcv_pkg::STAMP_W-1:0]  bar_stamp,
    output logic [ohlcv_pkg::PRICE_W-1:0]  bar_open,
    output logic [ohlcv_pkg::PRICE_W-1:0]  bar_high,
    output logic [ohlcv_pkg::PRICE_W-1:0]  bar_low,
    output logic [ohlcv_pkg::PRICE_W-1:0]  bar_close,
    output logic [ohlcv_pkg::SUM_W-1:0]    bar_volume,
    output logic [ohlcv_pkg::PRICE_W-1:0]  bar_bid,
    output logic [ohlcv_pkg::PRICE_W-1:0]  bar_ask
);
    import ohlcv_pkg::*;

    // prices are kept at the narrower of the port width and PRICE_BITS
    localparam int PB = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_GROUP);
    localparam logic [LEN_W-1:0] ONE_LEN = LEN_W'(1);
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [PB-1:0]    LOW_INIT = {PB{1'b1}};

    // configuration and group state
    logic [LEN_W-1:0]   eff_len_reg;
    logic [STAMP_W-1:0] start_time_reg;
    logic               started_reg;
    logic [LEN_W-1:0]   group_count_reg;
    logic [STAMP_W-1:0] first_stamp_reg;
    logic [PB-1:0]      first_open_reg;
    logic [PB-1:0]      high_reg;
    logic [PB-1:0]      low_reg;
    logic [SUM_W-1:0]   vol_reg;

    logic               started_next;
    logic [LEN_W-1:0]   group_count_next;
    logic [STAMP_W-1:0] first_stamp_next;
    logic [PB-1:0]      first_open_next;
    logic [PB-1:0]      high_next;
    logic [PB-1:0]      low_next;
    logic [SUM_W-1:0]   vol_next;

    // output queue
    bar_t               fifo_mem [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;

    logic               in_beat;
    logic               out_beat;
    logic               take;
    logic               done;
    logic [LEN_W-1:0]   count_inc;
    logic [PB-1:0]      hi_in;
    logic [PB-1:0]      lo_in;
    logic [PB-1:0]      op_in;
    logic [SUM_W:0]     vol_sum;
    logic [SUM_W-1:0]   vol_sat;
    logic [PB-1:0]      cand_open;
    logic [STAMP_W-1:0] cand_stamp;
    logic [LEN_W-1:0]   len_wr;
    bar_t               bar_new;
    bar_t               bar_head;

    assign in_ready = (count_reg != 2'd2);
    assign in_beat  = in_valid && in_ready;
    assign out_valid = (count_reg != 2'd0);
    assign out_beat = out_valid && out_ready;

    assign hi_in = high_price[PB-1:0];
    assign lo_in = low_price[PB-1:0];
    assign op_in = open_price[PB-1:0];

    // candle counts once started, or when it is the start candle
    assign take = in_beat && (started_reg || (stamp == start_time_reg));

    always_comb
    begin
        len_wr = cfg_data[LEN_W-1:0];
        if (len_wr == '0)
            len_wr = ONE_LEN;
        else if (len_wr > MAX_LEN)
            len_wr = MAX_LEN;
    end

    always_comb
    begin
        count_inc  = group_count_reg + ONE_LEN;
        done       = (count_inc >= eff_len_reg);
        cand_stamp = (group_count_reg == '0) ? stamp : first_stamp_reg;
        cand_open  = (group_count_reg == '0) ? op_in : first_open_reg;
        vol_sum    = {1'b0, vol_reg} + {{(SUM_W + 1 - VOL_W){1'b0}}, volume};
        vol_sat    = vol_sum[SUM_W] ? SUM_MAX : vol_sum[SUM_W-1:0];

        bar_new.stamp   = cand_stamp;
        bar_new.open_p  = PRICE_W'(cand_open);
        bar_new.high_p  = PRICE_W'((hi_in > high_reg) ? hi_in : high_reg);
        bar_new.low_p   = PRICE_W'((lo_in < low_reg) ? lo_in : low_reg);
        bar_new.close_p = PRICE_W'(close_price[PB-1:0]);
        bar_new.volume  = vol_sat;
        bar_new.bid_p   = PRICE_W'(bid_price[PB-1:0]);
        bar_new.ask_p   = PRICE_W'(ask_price[PB-1:0]);

        started_next     = started_reg;
        group_count_next = group_count_reg;
        first_stamp_next = first_stamp_reg;
        first_open_next  = first_open_reg;
        high_next        = high_reg;
        low_next         = low_reg;
        vol_next         = vol_reg;

        if (cfg_wr_en && (cfg_index == REG_BLOCK_LENGTH || cfg_index == REG_START_TIME))
        begin
            if (cfg_index == REG_START_TIME)
                started_next = 1'b0;
            group_count_next = '0;
            first_stamp_next = '0;
            first_open_next  = '0;
            high_next        = '0;
            low_next         = LOW_INIT;
            vol_next         = '0;
        end
        else if (take)
        begin
            started_next = 1'b1;
            if (done)
            begin
                group_count_next = '0;
                first_stamp_next = '0;
                first_open_next  = '0;
                high_next        = '0;
                low_next         = LOW_INIT;
                vol_next         = '0;
            end
            else
            begin
                group_count_next = count_inc;
                first_stamp_next = cand_stamp;
                first_open_next  = cand_open;
                high_next        = bar_new.high_p[PB-1:0];
                low_next         = bar_new.low_p[PB-1:0];
                vol_next         = vol_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_len_reg     <= ONE_LEN;
            start_time_reg  <= '0;
            started_reg     <= 1'b0;
            group_count_reg <= '0;
            first_stamp_reg <= '0;
            first_open_reg  <= '0;
            high_reg        <= '0;
            low_reg         <= LOW_INIT;
            vol_reg         <= '0;
            wr_ptr_reg      <= 1'b0;
            rd_ptr_reg      <= 1'b0;
            count_reg       <= 2'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_BLOCK_LENGTH: eff_len_reg <= len_wr;
                    REG_START_TIME:   start_time_reg <= cfg_data[STAMP_W-1:0];
                    default: ;
                endcase
            end
            started_reg     <= started_next;
            group_count_reg <= group_count_next;
            first_stamp_reg <= first_stamp_next;
            first_open_reg  <= first_open_next;
            high_reg        <= high_next;
            low_reg         <= low_next;
            vol_reg         <= vol_next;

            if (take && done)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (out_beat)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, take && done} - {1'b0, out_beat};
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (take && done)
            fifo_mem[wr_ptr_reg] <= bar_new;
    end

    assign bar_head   = fifo_mem[rd_ptr_reg];
    assign bar_stamp  = bar_head.stamp;
    assign bar_open   = bar_head.open_p;
    assign bar_high   = bar_head.high_p;
    assign bar_low    = bar_head.low_p;
    assign bar_close  = bar_head.close_p;
    assign bar_volume = bar_head.volume;
    assign bar_bid    = bar_head.bid_p;
    assign bar_ask    = bar_head.ask_p;

    // queue never holds more than two bars
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output queue overflow");

    // a running group is always shorter than the bar length
    a_group_short: assert property (@(posedge clk) disable iff (!rst_n)
        group_count_reg < eff_len_reg)
        else $error("group count reached bar length");

    // no partial group before the start candle
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !started_reg |-> (group_count_reg == '0))
        else $error("group open before start");

    // a closing candle with no drain grows the queue
    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        (take && done && !out_beat) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("bar not queued");

    // the effective length stays in its legal range
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (eff_len_reg != '0) && (eff_len_reg <= MAX_LEN))
        else $error("bar length out of range");

endmodule
